FILE: design/wer_pkg.sv
package wer_pkg;

  // Field widths
  localparam int TICK_W  = 48;
  localparam int WALL_W  = 32;
  localparam int PER_W   = 32;
  localparam int RATIO_W = 11;
  localparam int SHORT_W = 32;
  localparam int LONG_W  = 42;
  localparam int RATE_W  = 48;
  localparam int STAMP_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_RATIO    = 2'd1;
  localparam logic [PER_W-1:0]     PERIOD_RESET      = 32'd125000000;
  localparam logic [RATIO_W-1:0]   RATIO_RESET       = 11'd10;

  // Result kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // Rate arithmetic: count * 1e9 * 2^16 / divisor
  localparam int SEC_W   = 30;
  localparam logic [SEC_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam int HALF_W  = LONG_W / 2;
  localparam int ACC_W   = LONG_W + SEC_W;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = ACC_W + FRAC_W;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  // Job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Effective configuration (zero values already mapped to one)
  typedef struct packed {
    logic [PER_W-1:0]   period;
    logic [RATIO_W-1:0] ratio;
  } cfg_t;

  // One closed window handed to the back end
  typedef struct packed {
    logic [SHORT_W-1:0] short_cnt;
    logic [WALL_W-1:0]  wall;
    logic               has_long;
    logic [LONG_W-1:0]  long_sum;
    logic [LONG_W-1:0]  time_sum;
  } job_t;

endpackage

FILE: design/wer_if.sv
interface wer_in_if;
  logic                         valid;
  logic                         ready;
  logic [wer_pkg::TICK_W-1:0]   tick_time;
  logic [wer_pkg::WALL_W-1:0]   wall_time;
  logic                         count_flag;

  modport source (output valid, output tick_time, output wall_time, output count_flag,
                  input ready);
  modport sink   (input valid, input tick_time, input wall_time, input count_flag,
                  output ready);
endinterface

interface wer_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [wer_pkg::STAMP_W-1:0]  stamp;
  logic [wer_pkg::RATE_W-1:0]   rate;
  logic                         last;

  modport source (output valid, output kind, output stamp, output rate, output last,
                  input ready);
  modport sink   (input valid, input kind, input stamp, input rate, input last,
                  output ready);
endinterface

interface wer_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wer_pkg::CFG_IDX_W-1:0]   index;
  logic [wer_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/wer_front.sv
module wer_front (
  input  logic            clk,
  input  logic            rst_n,
  wer_in_if.sink          in_ch,
  input  wer_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output wer_pkg::job_t   q_job
);
  import wer_pkg::*;

  logic               started_r;
  logic [TICK_W-1:0]  ws_r;
  logic [SHORT_W-1:0] short_r;
  logic [LONG_W-1:0]  long_r;
  logic [LONG_W-1:0]  tsum_r;
  logic [RATIO_W-1:0] wc_r;

  logic               accept;
  logic [TICK_W:0]    end1;
  logic [TICK_W+1:0]  end2;
  logic               restart;
  logic               close;
  logic [LONG_W:0]    long_add;
  logic [LONG_W:0]    tsum_add;
  logic [LONG_W-1:0]  long_sat;
  logic [LONG_W-1:0]  tsum_sat;
  logic [RATIO_W:0]   wc_inc;
  logic               has_long;
  logic [SHORT_W-1:0] short_nxt;

  // Stall only when the job queue cannot take a window close
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the push against the current window
  always_comb begin
    end1     = {1'b0, ws_r} + (TICK_W+1)'(cfg.period);
    end2     = {2'b0, ws_r} + (TICK_W+2)'({cfg.period, 1'b0});
    restart  = !started_r || (ws_r > in_ch.tick_time) ||
               ({2'b0, in_ch.tick_time} > end2);
    close    = !restart && (end1 < {1'b0, in_ch.tick_time});
    long_add = {1'b0, long_r} + (LONG_W+1)'(short_r);
    tsum_add = {1'b0, tsum_r} + (LONG_W+1)'(in_ch.wall_time);
    long_sat = long_add[LONG_W] ? '1 : long_add[LONG_W-1:0];
    tsum_sat = tsum_add[LONG_W] ? '1 : tsum_add[LONG_W-1:0];
    wc_inc   = {1'b0, wc_r} + (RATIO_W+1)'(1);
    has_long = wc_inc >= {1'b0, cfg.ratio};
    if (restart || close) begin
      short_nxt = SHORT_W'(in_ch.count_flag);
    end else if (short_r != '1) begin
      short_nxt = short_r + SHORT_W'(in_ch.count_flag);
    end else begin
      short_nxt = short_r;
    end
  end

  // Hand each window close to the back end
  assign q_push         = accept && close;
  assign q_job.short_cnt = short_r;
  assign q_job.wall      = in_ch.wall_time;
  assign q_job.has_long  = has_long;
  assign q_job.long_sum  = long_sat;
  assign q_job.time_sum  = tsum_sat;

  // Advance the window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      ws_r      <= '0;
      short_r   <= '0;
      long_r    <= '0;
      tsum_r    <= '0;
      wc_r      <= '0;
    end else if (accept) begin
      short_r <= short_nxt;
      if (restart) begin
        started_r <= 1'b1;
        ws_r      <= in_ch.tick_time;
        long_r    <= '0;
        tsum_r    <= '0;
        wc_r      <= '0;
      end else if (close) begin
        ws_r <= end1[TICK_W-1:0];
        if (has_long) begin
          long_r <= '0;
          tsum_r <= '0;
          wc_r   <= '0;
        end else begin
          long_r <= long_sat;
          tsum_r <= tsum_sat;
          wc_r   <= wc_inc[RATIO_W-1:0];
        end
      end
    end
  end

endmodule

FILE: design/wer_queue.sv
module wer_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wer_pkg::job_t  push_job,
  input  logic           pop,
  output wer_pkg::job_t  head,
  output logic           full,
  output logic           empty
);
  import wer_pkg::*;

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: design/wer_back.sv
module wer_back #(
  parameter int NS_PER_TICK = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  wer_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  wer_pkg::job_t  q_head,
  output logic           q_pop,
  wer_out_if.source      out_ch
);
  import wer_pkg::*;

  localparam int NS_W  = $clog2(NS_PER_TICK + 1);
  localparam int D0_W  = PER_W + NS_W;
  localparam int DEN_W = D0_W + RATIO_W;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_MULA   = 3'd1;
  localparam logic [2:0] B_MULB   = 3'd2;
  localparam logic [2:0] B_DIVSET = 3'd3;
  localparam logic [2:0] B_DIV    = 3'd4;
  localparam logic [2:0] B_MEAN   = 3'd5;
  localparam logic [2:0] B_OUT    = 3'd6;

  logic [2:0]         state_r;
  job_t               job_r;
  logic               long_ph_r;
  logic [LONG_W-1:0]  mcnt_r;
  logic [D0_W-1:0]    d0_r;
  logic [ACC_W-1:0]   acc_r;
  logic [NUM_W-1:0]   div_num_r;
  logic [DEN_W-1:0]   div_den_r;
  logic [DEN_W-1:0]   div_rem_r;
  logic [RATE_W-1:0]  div_q_r;
  logic               div_ovf_r;
  logic [DCNT_W-1:0]  div_cnt_r;
  logic [RATE_W-1:0]  res_rate_r;
  logic [STAMP_W-1:0] res_stamp_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic [RATE_W-1:0]  out_rate_r;
  logic               out_last_r;

  logic [ACC_W-1:0]   mul_lo;
  logic [ACC_W-1:0]   mul_hi;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     rem_diff;
  logic               rem_ge;
  logic [DEN_W-1:0]   rem_n;
  logic [RATE_W-1:0]  q_n;
  logic               ovf_n;
  logic [RATE_W-1:0]  rate_fin;
  logic               out_free;
  logic               out_load;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == B_OUT) && out_free;

  // Partial products of count * 1e9, low and high halves
  assign mul_lo = ACC_W'(mcnt_r[HALF_W-1:0]) * ACC_W'(NS_PER_SEC);
  assign mul_hi = ACC_W'(mcnt_r[LONG_W-1:HALF_W]) * ACC_W'(NS_PER_SEC);

  // One restoring division step, quotient clamped at full scale
  always_comb begin
    rem_sh   = {div_rem_r, div_num_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, div_den_r};
    rem_ge   = rem_sh >= {1'b0, div_den_r};
    rem_n    = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    q_n      = {div_q_r[RATE_W-2:0], rem_ge};
    ovf_n    = div_ovf_r | div_q_r[RATE_W-1];
    rate_fin = ovf_n ? '1 : q_n;
  end

  // Sequence multiply, divide and result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      long_ph_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r     <= q_head;
            mcnt_r    <= LONG_W'(q_head.short_cnt);
            long_ph_r <= 1'b0;
            d0_r      <= D0_W'(cfg.period) * D0_W'(NS_PER_TICK);
            state_r   <= B_MULA;
          end
        end
        B_MULA: begin
          acc_r   <= mul_lo;
          state_r <= B_MULB;
        end
        B_MULB: begin
          acc_r <= acc_r + (mul_hi << HALF_W);
          if (long_ph_r) begin
            div_den_r <= DEN_W'(d0_r) * DEN_W'(cfg.ratio);
          end else begin
            div_den_r <= DEN_W'(d0_r);
          end
          state_r <= B_DIVSET;
        end
        B_DIVSET: begin
          div_num_r <= {acc_r, {FRAC_W{1'b0}}};
          div_rem_r <= '0;
          div_q_r   <= '0;
          div_ovf_r <= 1'b0;
          div_cnt_r <= DCNT_W'(NUM_W);
          state_r   <= B_DIV;
        end
        B_DIV: begin
          if (div_cnt_r == DCNT_W'(1)) begin
            res_rate_r <= rate_fin;
            if (long_ph_r) begin
              // Mean wall time of the averaged windows
              div_num_r <= {job_r.time_sum, {(NUM_W-LONG_W){1'b0}}};
              div_den_r <= DEN_W'(cfg.ratio);
              div_rem_r <= '0;
              div_q_r   <= '0;
              div_ovf_r <= 1'b0;
              div_cnt_r <= DCNT_W'(LONG_W);
              state_r   <= B_MEAN;
            end else begin
              res_stamp_r <= job_r.wall;
              state_r     <= B_OUT;
            end
          end else begin
            div_num_r <= div_num_r << 1;
            div_rem_r <= rem_n;
            div_q_r   <= q_n;
            div_ovf_r <= ovf_n;
            div_cnt_r <= div_cnt_r - DCNT_W'(1);
          end
        end
        B_MEAN: begin
          div_num_r <= div_num_r << 1;
          div_rem_r <= rem_n;
          div_q_r   <= q_n;
          div_ovf_r <= ovf_n;
          div_cnt_r <= div_cnt_r - DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(1)) begin
            res_stamp_r <= (q_n[RATE_W-1:STAMP_W] != '0) ? '1 : q_n[STAMP_W-1:0];
            state_r     <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_kind_r  <= long_ph_r ? KIND_LONG : KIND_SHORT;
            out_stamp_r <= res_stamp_r;
            out_rate_r  <= res_rate_r;
            out_last_r  <= long_ph_r || !job_r.has_long;
            if (!long_ph_r && job_r.has_long) begin
              long_ph_r <= 1'b1;
              mcnt_r    <= job_r.long_sum;
              state_r   <= B_MULA;
            end else begin
              state_r <= B_IDLE;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.stamp = out_stamp_r;
  assign out_ch.rate  = out_rate_r;
  assign out_ch.last  = out_last_r;

endmodule

FILE: design/windowed_event_rate_meter.sv
// Windowed event rate meter. The front end takes one push per cycle while the
// job queue is not full: it tracks the window start, counts flagged events and,
// on a window close, queues a job for the back end. The back end turns each job
// into a short rate (events per second, Q32.16, saturated, stamped with the
// push's wall time) and, every long_ratio windows, a long average rate stamped
// with the mean wall time. It does this with two 21x30 multipliers for the
// partial products and a one-bit-per-cycle restoring divider, which takes 88
// steps for each rate and 42 for the mean. The queue holds two closed windows;
// while it is full every push is stalled, whether or not it closes a window. A
// result waits in the output register while the back end keeps working. A
// period or ratio of zero acts as one.
module windowed_event_rate_meter #(
  parameter int NS_PER_TICK = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  wer_in_if.sink  in_ch,
  wer_out_if.source out_ch,
  wer_cfg_if.sink cfg_ch
);
  import wer_pkg::*;

  logic [PER_W-1:0]   period_r;
  logic [RATIO_W-1:0] ratio_r;
  cfg_t               cfg;
  logic               q_push;
  job_t               q_job;
  logic               q_pop;
  job_t               q_head;
  logic               q_full;
  logic               q_empty;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      ratio_r  <= RATIO_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_WINDOW_PERIOD: period_r <= cfg_ch.data[PER_W-1:0];
        CFG_LONG_RATIO:    ratio_r  <= cfg_ch.data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Map zero settings to one
  assign cfg.period = (period_r == '0) ? PER_W'(1) : period_r;
  assign cfg.ratio  = (ratio_r == '0) ? RATIO_W'(1) : ratio_r;

  wer_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  wer_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wer_back #(
    .NS_PER_TICK (NS_PER_TICK)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: bench/wer_rate_check.sv
module wer_rate_check #(
  parameter int NS_PER_TICK = 8
) (
  input  logic clk,
  input  logic rst_n,
  wer_in_if    in_mon,
  wer_out_if   out_mon,
  wer_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   short_seen,
  output int   long_seen,
  output int   sat_seen,
  output int   restart_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import wer_pkg::*;

  localparam logic [63:0]         Q16_NS_PER_SEC = 64'd65536000000000;
  localparam logic [RATE_W-1:0]   RATE_MAX       = '1;
  localparam logic [LONG_W-1:0]   LONG_MAX       = '1;
  localparam logic [STAMP_W-1:0]  STAMP_MAX      = '1;
  localparam int                  SHOWN_MAX      = 10;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] stamp;
    logic [RATE_W-1:0]  rate;
    logic               last;
  } rate_rec_t;

  rate_rec_t expected_rates[$];

  // Mirror of the meter state and its registers
  logic               started;
  logic [TICK_W-1:0]  win_start;
  logic [SHORT_W-1:0] short_cnt;
  logic [LONG_W-1:0]  long_cnt;
  logic [LONG_W-1:0]  wall_sum;
  logic [RATIO_W-1:0] win_cnt;
  logic [PER_W-1:0]   period_reg;
  logic [RATIO_W-1:0] ratio_reg;

  // Events per second in Q32.16, truncated, clamped to the 48-bit maximum
  function automatic logic [RATE_W-1:0] q16_rate(input logic [LONG_W-1:0] events,
                                                 input logic [63:0] span_ns);
    logic [127:0] quo;
    quo = (128'(events) * 128'(Q16_NS_PER_SEC)) / 128'(span_ns);
    return (quo > 128'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
  endfunction

  // Advance the mirrored window for one push and queue the rates it closes
  task automatic predict_push(input logic [TICK_W-1:0] tick, input logic [WALL_W-1:0] wall,
                              input logic flag);
    logic [63:0] per;
    logic [63:0] rat;
    logic [63:0] acc;
    logic [63:0] mean;
    rate_rec_t   short_r;
    rate_rec_t   long_r;
    logic        with_long;
    per = (period_reg == '0) ? 64'd1 : 64'(period_reg);
    rat = (ratio_reg == '0) ? 64'd1 : 64'(ratio_reg);
    with_long = 1'b0;
    if (!started || win_start > tick || 64'(tick) > 64'(win_start) + 2 * per) begin
      started = 1'b1;
      win_start = tick;
      short_cnt = '0;
      long_cnt = '0;
      wall_sum = '0;
      win_cnt = '0;
      restart_seen++;
    end else if (64'(win_start) + per < 64'(tick)) begin
      win_start = win_start + per[TICK_W-1:0];
      short_r.kind = KIND_SHORT;
      short_r.stamp = wall;
      short_r.rate = q16_rate(LONG_W'(short_cnt), per * 64'(NS_PER_TICK));
      short_r.last = 1'b1;
      acc = 64'(long_cnt) + 64'(short_cnt);
      long_cnt = (acc > 64'(LONG_MAX)) ? LONG_MAX : acc[LONG_W-1:0];
      acc = 64'(wall_sum) + 64'(wall);
      wall_sum = (acc > 64'(LONG_MAX)) ? LONG_MAX : acc[LONG_W-1:0];
      if (64'(win_cnt) + 64'd1 >= rat) begin
        mean = 64'(wall_sum) / rat;
        long_r.kind = KIND_LONG;
        long_r.stamp = (mean > 64'(STAMP_MAX)) ? STAMP_MAX : mean[STAMP_W-1:0];
        long_r.rate = q16_rate(long_cnt, per * 64'(NS_PER_TICK) * rat);
        long_r.last = 1'b1;
        short_r.last = 1'b0;
        with_long = 1'b1;
        long_cnt = '0;
        wall_sum = '0;
        win_cnt = '0;
      end else begin
        win_cnt = win_cnt + 1'b1;
      end
      short_cnt = '0;
      expected_rates.push_back(short_r);
      if (with_long) expected_rates.push_back(long_r);
    end
    if (short_cnt != '1) short_cnt = short_cnt + SHORT_W'(flag);
  endtask

  // Compare one delivered rate with the oldest expectation
  task automatic check_rate(input logic kind, input logic [STAMP_W-1:0] stamp,
                            input logic [RATE_W-1:0] rate, input logic last);
    rate_rec_t want;
    if (expected_rates.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOWN_MAX)
        $display("%0t: rate result with nothing pending: kind %0d stamp %0d rate %0d last %0d",
                 $realtime, kind, stamp, rate, last);
    end else begin
      want = expected_rates.pop_front();
      if (want.kind != kind || want.stamp != stamp || want.rate != rate || want.last != last)
      begin
        fail_count++;
        if (fail_count <= SHOWN_MAX) begin
          $display("%0t: rate mismatch", $realtime);
          $display("  expected kind %0d stamp %0d rate %0d last %0d",
                   want.kind, want.stamp, want.rate, want.last);
          $display("  actual   kind %0d stamp %0d rate %0d last %0d", kind, stamp, rate, last);
        end
      end
      if (kind == KIND_LONG) long_seen++;
      else short_seen++;
      if (rate == RATE_MAX) sat_seen++;
    end
  endtask

  // Track register writes, check results, then predict new pushes
  always @(posedge clk) begin
    if (!rst_n) begin
      started = 1'b0;
      win_start = '0;
      short_cnt = '0;
      long_cnt = '0;
      wall_sum = '0;
      win_cnt = '0;
      period_reg = PERIOD_RESET;
      ratio_reg = RATIO_RESET;
      expected_rates.delete();
      fail_count = 0;
      pending = 0;
      short_seen = 0;
      long_seen = 0;
      sat_seen = 0;
      restart_seen = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_WINDOW_PERIOD: period_reg = cfg_mon.data[PER_W-1:0];
          CFG_LONG_RATIO:    ratio_reg = cfg_mon.data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready)
        check_rate(out_mon.kind, out_mon.stamp, out_mon.rate, out_mon.last);
      if (in_mon.valid && in_mon.ready)
        predict_push(in_mon.tick_time, in_mon.wall_time, in_mon.count_flag);
      pending = expected_rates.size();
    end
  end

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wer_pkg::*;

  localparam int NS_PER_TICK    = 8;
  localparam int RX_HOLD_CYCLES = 2000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int STALL_LIMIT    = 10000;
  localparam int IDLE_PCT       = 36;
  localparam int BURST_LEN      = 50;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [TICK_W-1:0]    TICK_MAX    = '1;
  localparam logic [WALL_W-1:0]    WALL_MAX    = '1;
  localparam logic [TICK_W-1:0]    T0          = 48'd1000;
  localparam logic [TICK_W-1:0]    P0          = TICK_W'(PERIOD_RESET);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  int fail_count;
  int pending;
  int short_seen;
  int long_seen;
  int sat_seen;
  int restart_seen;
  int pushes_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  wer_in_if  in_ch ();
  wer_out_if out_ch ();
  wer_cfg_if cfg_ch ();

  windowed_event_rate_meter #(
    .NS_PER_TICK(NS_PER_TICK)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  wer_rate_check #(
    .NS_PER_TICK(NS_PER_TICK)
  ) rate_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .short_seen  (short_seen),
    .long_seen   (long_seen),
    .sat_seen    (sat_seen),
    .restart_seen(restart_seen)
  );

  // Abort when no channel completes a transfer for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
      $display("windowed_event_rate_meter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one push after a random gap; valid stays high after the transfer
  task automatic push(input logic [TICK_W-1:0] tick, input logic [WALL_W-1:0] wall,
                      input logic flag);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick_time <= tick;
    in_ch.wall_time <= wall;
    in_ch.count_flag <= flag;
    do @(posedge clk); while (!in_ch.ready);
    pushes_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_writes++;
  endtask

  // Write both registers, optionally poke the unused indexes too
  task automatic set_config(input logic [PER_W-1:0] per, input logic [CFG_DATA_W-1:0] ratio_word,
                            input bit spare);
    cfg_write(CFG_WINDOW_PERIOD, per);
    cfg_write(CFG_LONG_RATIO, ratio_word);
    if (spare) begin
      cfg_write(CFG_SPARE_2, $urandom);
      cfg_write(CFG_SPARE_3, $urandom);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, drain every pending rate, then let the back end go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly in-order ticks that close windows, with bursts and some restarts
  task automatic random_phase(input logic [PER_W-1:0] per_raw, input int n_items);
    logic [63:0]       per;
    logic [63:0]       cur;
    logic [63:0]       tick;
    logic [63:0]       back;
    logic [WALL_W-1:0] wall;
    logic              flag;
    int                burst;
    int                sel;
    per = (per_raw == '0) ? 64'd1 : 64'(per_raw);
    cur = {$urandom, $urandom} & (64'(TICK_MAX) >> $urandom_range(47));
    burst = 0;
    for (int i = 0; i < n_items; i++) begin
      if (cur + 3 * per + 64'd4096 > 64'(TICK_MAX)) cur = 64'($urandom);
      if (per == 64'd1 && i == n_items / 2) burst = BURST_LEN;
      flag = ($urandom_range(99) < 75);
      sel = $urandom_range(99);
      if (burst > 0) begin
        // pile counted events onto one tick to push the rate into saturation
        burst--;
        tick = cur;
        flag = 1'b1;
      end else if (sel < 3) begin
        back = 64'($urandom_range(1000, 1));
        tick = (cur > back) ? cur - back : 64'd0;
      end else if (sel < 6) begin
        tick = cur + 2 * per + 64'($urandom_range(1000, 1));
      end else if (sel < 8) begin
        tick = {$urandom, $urandom} & 64'(TICK_MAX);
      end else if (sel == 8) begin
        burst = BURST_LEN / 5;
        tick = cur;
      end else begin
        sel = $urandom_range(99);
        if (sel < 35) tick = cur;
        else if (sel < 75) tick = cur + 64'($urandom_range(32'(per >> 2), 0));
        else tick = cur + 64'($urandom_range(32'(per), 32'(per >> 1)));
      end
      cur = tick;
      sel = $urandom_range(19);
      wall = (sel == 0) ? '0 : (sel == 1) ? WALL_MAX : $urandom;
      push(tick[TICK_W-1:0], wall, flag);
    end
  endtask

  initial begin
    logic [PER_W-1:0]   rnd_per;
    logic [RATIO_W-1:0] rnd_ratio;

    in_ch.valid <= 1'b0;
    in_ch.tick_time <= '0;
    in_ch.wall_time <= '0;
    in_ch.count_flag <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_WINDOW_PERIOD;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: first push, window edge, exact two-period close, restarts
    push(T0, 32'd5, 1'b1);
    push(T0, '0, 1'b1);
    push(T0 + P0, WALL_MAX, 1'b1);
    push(T0 + P0 + 1, 32'd7, 1'b0);
    push(T0 + 3 * P0, 32'd9, 1'b1);
    push(48'd5, 32'd11, 1'b1);
    push(TICK_MAX, 32'd13, 1'b1);
    push(TICK_MAX, WALL_MAX, 1'b1);

    // Zero period acts as one tick, short and long closes back to back
    settle();
    set_config('0, 32'd2, 1'b0);
    push(48'd40, 32'd1, 1'b1);
    push(48'd41, 32'd2, 1'b1);
    push(48'd42, 32'd3, 1'b1);
    push(48'd43, 32'd4, 1'b1);
    push(48'd46, 32'd5, 1'b1);

    // Fill nine windows, then lower the ratio so the mean time saturates
    settle();
    set_config(32'd4, 32'd10, 1'b0);
    push(48'd100, WALL_MAX, 1'b1);
    for (int k = 0; k < 9; k++) push(48'd105 + 48'(4 * k), WALL_MAX, 1'b1);
    settle();
    set_config(32'd4, 32'd1, 1'b0);
    push(48'd141, WALL_MAX, 1'b1);

    // Random phases across register settings
    settle();
    set_config(32'd1, 32'd1, 1'b0);
    random_phase(32'd1, 200);

    settle();
    set_config('0, '0, 1'b1);
    random_phase('0, 150);

    settle();
    set_config(32'd3, {21'($urandom), 11'd5}, 1'b0);
    calm = 1'b1;
    random_phase(32'd3, 170);
    calm = 1'b0;

    settle();
    set_config(32'd7, {21'($urandom), 11'd2}, 1'b0);
    hold_req = 1'b1;
    random_phase(32'd7, 150);

    settle();
    set_config(32'hFFFF_FFFF, {21'($urandom), 11'd3}, 1'b0);
    random_phase(32'hFFFF_FFFF, 120);

    settle();
    set_config(PERIOD_RESET, 32'd4, 1'b0);
    random_phase(PERIOD_RESET, 120);

    settle();
    set_config(32'd20, {21'($urandom), 11'h7FF}, 1'b0);
    random_phase(32'd20, 80);

    settle();
    rnd_per = 32'($urandom_range(50, 2));
    rnd_ratio = 11'($urandom_range(8, 1));
    set_config(rnd_per, {21'($urandom), rnd_ratio}, 1'b0);
    random_phase(rnd_per, 150);

    settle();
    set_config(32'd5, 32'd1024, 1'b0);
    random_phase(32'd5, 80);

    settle();
    $display("covered %0d pushes, %0d register writes, %0d window restarts",
             pushes_sent, cfg_writes, restart_seen);
    $display("checked %0d short and %0d long rates, %0d of them saturated",
             short_seen, long_seen, sat_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("windowed_event_rate_meter regression: pass");
    end else begin
      if (pending != 0) $display("%0d expected rates never arrived", pending);
      $display("%0d mismatches", fail_count);
      $display("windowed_event_rate_meter regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/wer_pkg.sv
design/wer_if.sv
design/wer_front.sv
design/wer_queue.sv
design/wer_back.sv
design/windowed_event_rate_meter.sv
bench/wer_rate_check.sv
bench/tb.sv
